FILE: sv/pli_pkg.sv
`default_nettype none
package pli_pkg;

    localparam int COORD_W     = 24;
    localparam int DIFF_W      = COORD_W + 1;
    localparam int WIDE_W      = 2 * COORD_W + 3;   // den, na, nb
    localparam int SPLIT_L     = COORD_W + 2;       // low part of na for the split multiply
    localparam int OPA_W       = SPLIT_L + 1;
    localparam int PL_W        = OPA_W + DIFF_W;
    localparam int NUM_W       = 3 * COORD_W + 6;
    localparam int QB          = COORD_W + 1;       // quotient bits kept before saturation
    localparam int QCW         = $clog2(QB);
    localparam int V_W         = COORD_W + 3;
    localparam int SIDE_W      = 5;
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int Q_DEPTH     = 2;

    localparam logic [1:0] MODE_APPEND = 2'd0;
    localparam logic [1:0] MODE_QUERY  = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic signed [V_W-1:0] V_LIM_HI = V_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [V_W-1:0] V_LIM_LO = V_W'(-(1 << (COORD_W - 1)));
    localparam logic signed [COORD_W-1:0] COORD_MAX = COORD_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [COORD_W-1:0] COORD_MIN = COORD_W'(-(1 << (COORD_W - 1)));

    typedef struct packed {
        logic [1:0]                mode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic [SIDE_W-1:0]         side_number;
        logic                      hit_found;
        logic                      saturated;
        logic                      last_hit;
    } t_out;

    typedef struct packed {
        logic [1:0]                op;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [DIFF_W-1:0]  dx1;
        logic signed [DIFF_W-1:0]  dy1;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage
`default_nettype wire

FILE: sv/polygon_line_intersector.sv
// Polygon / line intersector.
// Input channel (i_valid, o_stall, i_item): mode 0 appends a corner, mode 2
// clears the polygon, mode 1 queries the infinite line through point and end
// against every side of the closed polygon. Mode 3 is accepted and dropped.
// Output channel (o_valid, i_stall, o_result): one transfer per side hit, up
// to MAX_RESULTS, in side order, the last with last_hit set; a query with no
// hit gives one marker with hit_found clear. Appends and clears give none.
// A front stage takes items and precomputes the line direction, a two-entry
// queue decouples it from the back end, which walks the sides with two
// shared multipliers and one bit-serial divider.
// A query walks the sides in order; a side with a zero denominator or a miss
// ends early, while a side hit runs the divider (one quotient bit a cycle)
// once for each of its two coordinates.
// At reset the polygon is empty and both channels are idle. When the
// receiver stalls, the result waits in an output register; the walk halts at
// the next hit until it is taken, while the front keeps taking items until
// the queue fills.
`default_nettype none
module polygon_line_intersector #(
    parameter int MAX_VERTICES = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  pli_pkg::t_in      i_item,
    output logic              o_valid,
    input  wire               i_stall,
    output pli_pkg::t_out     o_result
);

    logic             push;
    logic             pop;
    pli_pkg::t_cmd    front_cmd;
    pli_pkg::t_cmd    queue_cmd;
    pli_pkg::t_qstat  qstat;

    pli_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (front_cmd)
    );

    pli_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_qstat (qstat)
    );

    pli_back #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (queue_cmd),
        .i_qstat  (qstat),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

endmodule
`default_nettype wire

FILE: sv/pli_front.sv
`default_nettype none
module pli_front (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_valid,
    output logic              o_stall,
    input  pli_pkg::t_in      i_item,
    input  pli_pkg::t_qstat   i_qstat,
    output logic              o_push,
    output pli_pkg::t_cmd     o_cmd
);

    logic          r_v;
    pli_pkg::t_in  r_item;
    logic          drop;
    logic          fire;

    // unknown modes are discarded here and never reach the queue
    assign drop = !(r_item.mode == pli_pkg::MODE_APPEND ||
                    r_item.mode == pli_pkg::MODE_QUERY  ||
                    r_item.mode == pli_pkg::MODE_CLEAR);
    assign fire    = r_v && (drop || !i_qstat.full);
    assign o_push  = r_v && !drop && !i_qstat.full;
    assign o_stall = r_v && !fire;

    always_comb begin
        o_cmd.op      = r_item.mode;
        o_cmd.point_x = r_item.point_x;
        o_cmd.point_y = r_item.point_y;
        o_cmd.dx1     = pli_pkg::DIFF_W'(r_item.end_x) - pli_pkg::DIFF_W'(r_item.point_x);
        o_cmd.dy1     = pli_pkg::DIFF_W'(r_item.end_y) - pli_pkg::DIFF_W'(r_item.point_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_valid && !o_stall) begin
            r_v <= 1'b1;
        end else if (fire) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= i_item;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pli_queue.sv
`default_nettype none
module pli_queue (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_push,
    input  pli_pkg::t_cmd     i_cmd,
    input  wire               i_pop,
    output pli_pkg::t_cmd     o_cmd,
    output pli_pkg::t_qstat   o_qstat
);

    localparam int PW = $clog2(pli_pkg::Q_DEPTH);
    localparam int CW = $clog2(pli_pkg::Q_DEPTH + 1);

    pli_pkg::t_cmd r_mem [pli_pkg::Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          do_push;
    logic          do_pop;

    assign o_qstat.full  = (r_cnt == CW'(pli_pkg::Q_DEPTH));
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PW'(pli_pkg::Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(pli_pkg::Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pli_div.sv
`default_nettype none
module pli_div (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_start,
    input  wire [pli_pkg::NUM_W-1:0]         i_num,
    input  wire [pli_pkg::WIDE_W-1:0]        i_den,
    output logic                             o_done,
    output logic [pli_pkg::QB-1:0]           o_quo,
    output logic                             o_ovf
);

    logic                          r_busy;
    logic                          r_done;
    logic [pli_pkg::QCW-1:0]       r_step;
    logic [pli_pkg::NUM_W-1:0]     r_rem;
    logic [pli_pkg::NUM_W-1:0]     r_dsh;
    logic [pli_pkg::QB-1:0]        r_quo;
    logic                          r_ovf;
    logic                          ge;

    assign ge     = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_ovf  = r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // restoring, one quotient bit a cycle; quotients past QB bits only flag overflow
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_num;
            r_dsh  <= pli_pkg::NUM_W'(i_den) << (pli_pkg::QB - 1);
            r_ovf  <= (i_num >= (pli_pkg::NUM_W'(i_den) << pli_pkg::QB));
            r_quo  <= '0;
            r_step <= pli_pkg::QCW'(pli_pkg::QB - 1);
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= r_rem - r_dsh;
            end
            r_quo  <= {r_quo[pli_pkg::QB-2:0], ge};
            r_dsh  <= r_dsh >> 1;
            r_step <= r_step - 1'b1;
        end
    end

endmodule
`default_nettype wire

FILE: sv/pli_back.sv
`default_nettype none
module pli_back #(
    parameter int MAX_VERTICES = 32
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  pli_pkg::t_cmd     i_cmd,
    input  pli_pkg::t_qstat   i_qstat,
    output logic              o_pop,
    output logic              o_valid,
    input  wire               i_stall,
    output pli_pkg::t_out     o_result
);

    localparam int KW = $clog2(MAX_VERTICES);
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int CO = pli_pkg::COORD_W;
    localparam int DW = pli_pkg::DIFF_W;
    localparam int WW = pli_pkg::WIDE_W;
    localparam int NW = pli_pkg::NUM_W;
    localparam int VW = pli_pkg::V_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_DIFF = 4'd2;
    localparam logic [3:0] S_M0   = 4'd3;
    localparam logic [3:0] S_M1   = 4'd4;
    localparam logic [3:0] S_M2   = 4'd5;
    localparam logic [3:0] S_M3   = 4'd6;
    localparam logic [3:0] S_PL   = 4'd7;
    localparam logic [3:0] S_NUM  = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_HIT  = 4'd10;
    localparam logic [3:0] S_END  = 4'd11;

    logic [3:0]                     r_state;
    logic [CW-1:0]                  r_n;
    logic [KW-1:0]                  r_k;
    logic [pli_pkg::RES_CNT_W-1:0]  r_cnt;
    logic                           r_c;
    logic                           r_pend_v;
    logic                           r_out_v;
    pli_pkg::t_out                  r_pend;
    pli_pkg::t_out                  r_hit;
    pli_pkg::t_out                  r_out;

    logic signed [CO-1:0] r_mem_x [MAX_VERTICES];
    logic signed [CO-1:0] r_mem_y [MAX_VERTICES];
    logic signed [CO-1:0] r_px, r_py, r_ax, r_ay, r_bx, r_by, r_hx;
    logic signed [DW-1:0] r_dx1, r_dy1, r_dx2, r_dy2, r_dx13, r_dy13;
    logic signed [pli_pkg::PL_W-1:0] r_p0, r_p1;
    logic signed [WW-1:0] r_den, r_na;
    logic                 r_sat;
    logic                 r_neg;

    logic                 slot_free;
    logic                 out_load;
    logic                 last_side;
    logic                 cap;
    logic [KW-1:0]        k2;
    logic                 mem_we;
    logic signed [pli_pkg::OPA_W-1:0] a0, a1;
    logic signed [DW-1:0] b0, b1;
    logic signed [pli_pkg::PL_W-1:0] mul0, mul1;
    logic signed [WW-1:0] diff, den_n, na_n, nb_n;
    logic                 nb_fail;
    logic signed [NW-1:0] num, big_n;
    logic [NW-1:0]        div_num;
    logic                 div_start;
    logic                 div_done;
    logic [pli_pkg::QB-1:0] div_quo;
    logic                 div_ovf;
    logic signed [CO-1:0] start;
    logic signed [VW-1:0] vq, vst, v;
    logic                 hi_sat, lo_sat;
    logic signed [CO-1:0] coord;
    pli_pkg::t_out        marker;
    pli_pkg::t_out        pend_last;

    assign slot_free = !r_out_v || !i_stall;
    // result register takes a new transfer only while it is free or being emptied
    assign out_load  = slot_free && ((r_state == S_HIT && r_pend_v) || r_state == S_END);
    assign last_side = (CW'(r_k) + 1'b1 == r_n);
    assign cap       = (r_cnt + 1'b1 == pli_pkg::RES_CNT_W'(pli_pkg::MAX_RESULTS));
    assign k2        = (CW'(r_k) + 1'b1 < r_n) ? r_k + 1'b1 : '0;
    assign o_pop     = (r_state == S_IDLE) && !i_qstat.empty;
    assign mem_we    = o_pop && i_cmd.op == pli_pkg::MODE_APPEND && r_n < CW'(MAX_VERTICES);
    assign o_valid   = r_out_v;
    assign o_result  = r_out;

    // two shared multipliers; operands follow the step of the side test
    always_comb begin
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        unique case (r_state)
            S_M0: begin
                a0 = pli_pkg::OPA_W'(r_dy2);  b0 = r_dx1;
                a1 = pli_pkg::OPA_W'(r_dx2);  b1 = r_dy1;
            end
            S_M1: begin
                a0 = pli_pkg::OPA_W'(r_dx2);  b0 = r_dy13;
                a1 = pli_pkg::OPA_W'(r_dy2);  b1 = r_dx13;
            end
            S_M2: begin
                a0 = pli_pkg::OPA_W'(r_dx1);  b0 = r_dy13;
                a1 = pli_pkg::OPA_W'(r_dy1);  b1 = r_dx13;
            end
            S_PL: begin
                a0 = $signed({1'b0, r_na[pli_pkg::SPLIT_L-1:0]});
                a1 = pli_pkg::OPA_W'($signed(r_na[WW-1:pli_pkg::SPLIT_L]));
                b0 = r_c ? r_dy1 : r_dx1;
                b1 = r_c ? r_dy1 : r_dx1;
            end
            default: begin
            end
        endcase
    end

    assign mul0 = a0 * b0;
    assign mul1 = a1 * b1;
    assign diff = WW'(r_p0) - WW'(r_p1);

    always_comb begin
        den_n   = r_den[WW-1] ? -r_den : r_den;
        na_n    = r_den[WW-1] ? -r_na  : r_na;
        nb_n    = r_den[WW-1] ? -diff  : diff;
        nb_fail = nb_n[WW-1] || (nb_n > den_n);
    end

    // round to nearest: floor((2*na*d + den) / (2*den)); for negative N use ~N
    always_comb begin
        num     = (NW'(r_p1) <<< pli_pkg::SPLIT_L) + NW'(r_p0);
        big_n   = (num <<< 1) + NW'(r_den);
        div_num = big_n[NW-1] ? ~big_n : big_n;
    end
    assign div_start = (r_state == S_NUM);

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   ({r_den[WW-2:0], 1'b0}),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_ovf   (div_ovf)
    );

    always_comb begin
        start  = r_c ? r_py : r_px;
        vq     = $signed(VW'({1'b0, div_quo}));
        vst    = VW'(start);
        v      = r_neg ? vst - vq - VW'(1) : vst + vq;
        hi_sat = (div_ovf && !r_neg) || (!div_ovf && v > pli_pkg::V_LIM_HI);
        lo_sat = (div_ovf && r_neg)  || (!div_ovf && v < pli_pkg::V_LIM_LO);
        if (hi_sat) begin
            coord = pli_pkg::COORD_MAX;
        end else if (lo_sat) begin
            coord = pli_pkg::COORD_MIN;
        end else begin
            coord = v[CO-1:0];
        end
    end

    always_comb begin
        marker             = '0;
        marker.last_hit    = 1'b1;
        pend_last          = r_pend;
        pend_last.last_hit = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_n      <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_out_v <= out_load || (r_out_v && i_stall);
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop) begin
                        unique case (i_cmd.op)
                            pli_pkg::MODE_APPEND: begin
                                if (mem_we) begin
                                    r_n <= r_n + 1'b1;
                                end
                            end
                            pli_pkg::MODE_CLEAR: begin
                                r_n <= '0;
                            end
                            default: begin
                                r_pend_v <= 1'b0;
                                r_state  <= (r_n == '0) ? S_END : S_RD;
                            end
                        endcase
                    end
                end
                S_RD:   r_state <= S_DIFF;
                S_DIFF: r_state <= S_M0;
                S_M0:   r_state <= S_M1;
                S_M1:   r_state <= S_M2;
                S_M2: begin
                    if (r_den == '0) begin
                        r_state <= last_side ? S_END : S_RD;
                    end else begin
                        r_state <= S_M3;
                    end
                end
                S_M3: begin
                    if (nb_fail) begin
                        r_state <= last_side ? S_END : S_RD;
                    end else begin
                        r_state <= S_PL;
                    end
                end
                S_PL:  r_state <= S_NUM;
                S_NUM: r_state <= S_DIV;
                S_DIV: begin
                    if (div_done) begin
                        r_state <= r_c ? S_HIT : S_PL;
                    end
                end
                S_HIT: begin
                    // the previous hit goes out only once another is known to follow
                    if (!r_pend_v || slot_free) begin
                        r_pend_v <= 1'b1;
                        r_state  <= (last_side || cap) ? S_END : S_RD;
                    end
                end
                S_END: begin
                    if (slot_free) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_px  <= i_cmd.point_x;
                r_py  <= i_cmd.point_y;
                r_dx1 <= i_cmd.dx1;
                r_dy1 <= i_cmd.dy1;
                r_k   <= '0;
                r_cnt <= '0;
            end
            S_DIFF: begin
                r_dx2  <= DW'(r_bx) - DW'(r_ax);
                r_dy2  <= DW'(r_by) - DW'(r_ay);
                r_dx13 <= DW'(r_px) - DW'(r_ax);
                r_dy13 <= DW'(r_py) - DW'(r_ay);
            end
            S_M0: begin
                r_p0 <= mul0;
                r_p1 <= mul1;
            end
            S_M1: begin
                r_den <= diff;
                r_p0  <= mul0;
                r_p1  <= mul1;
            end
            S_M2: begin
                r_na <= diff;
                r_p0 <= mul0;
                r_p1 <= mul1;
                if (r_den == '0) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_M3: begin
                r_den <= den_n;
                r_na  <= na_n;
                r_c   <= 1'b0;
                if (nb_fail) begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_PL: begin
                r_p0 <= mul0;
                r_p1 <= mul1;
            end
            S_NUM: begin
                r_neg <= big_n[NW-1];
            end
            S_DIV: begin
                if (div_done) begin
                    if (!r_c) begin
                        r_hx  <= coord;
                        r_sat <= hi_sat || lo_sat;
                        r_c   <= 1'b1;
                    end else begin
                        r_hit.hit_x       <= r_hx;
                        r_hit.hit_y       <= coord;
                        r_hit.side_number <= pli_pkg::SIDE_W'(r_k);
                        r_hit.hit_found   <= 1'b1;
                        r_hit.saturated   <= r_sat || hi_sat || lo_sat;
                        r_hit.last_hit    <= 1'b0;
                    end
                end
            end
            S_HIT: begin
                if (!r_pend_v || slot_free) begin
                    if (out_load) begin
                        r_out <= r_pend;
                    end
                    r_pend <= r_hit;
                    r_cnt  <= r_cnt + 1'b1;
                    r_k    <= r_k + 1'b1;
                end
            end
            S_END: begin
                if (slot_free) begin
                    r_out <= r_pend_v ? pend_last : marker;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[KW'(r_n)] <= i_cmd.point_x;
            r_mem_y[KW'(r_n)] <= i_cmd.point_y;
        end
        r_ax <= r_mem_x[r_k];
        r_ay <= r_mem_y[r_k];
        r_bx <= r_mem_x[k2];
        r_by <= r_mem_y[k2];
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CW'(MAX_VERTICES))
        else $error("corner count beyond capacity");

    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_cnt != '0))
        else $error("pending hit without a hit count");

    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_v)
        else $error("pending hit left over after a query");

    a_slot_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && i_stall) |=> (r_out_v && $stable(r_out)))
        else $error("result slot overwritten while stalled");

endmodule
`default_nettype wire
